// File: rtl/tes_pkg.sv
// shared types and constants of the text encoding sniffer
package tes_pkg;

  typedef enum logic [2:0] {
    ENC_ASCII    = 3'd0,
    ENC_UTF8     = 3'd1,
    ENC_UTF32BE  = 3'd2,
    ENC_UTF32LE  = 3'd3,
    ENC_LATIN1   = 3'd4,
    ENC_EXTENDED = 3'd5,
    ENC_UNKNOWN  = 3'd6
  } encoding_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    encoding_e encoding;
    logic      has_bom;
  } result_t;

  localparam logic [31:0] LimitReset = 32'd150000;
  localparam logic [31:0] Bom32Word  = 32'h0000_feff;
  localparam logic [23:0] Utf8Bom    = 24'hef_bb_bf;
  localparam int unsigned OutPadBits = 4;

endpackage

// File: rtl/text_encoding_sniffer.sv
// top level of the text encoding sniffer: input, config and result registers
//
// a file enters on the slave stream one byte per transaction, tlast on the
// final byte. every byte runs through all encoding tests at once; only the
// final byte yields a transaction on the master stream, holding the encoding
// code and the byte-order mark flag.
// the code point limit for the utf-32 tests is written on the cfg channel,
// which is always ready; write it only while no file is in flight.
// throughput: one byte per cycle, set by the single test stage between the
// input register and the result register.
// the final byte passes the input register and then the result register,
// from which the master stream offers the result.
// a stalled master side holds the result; one more file's bytes keep
// flowing until its own final byte waits in the input register.
// reset clears all running tests, empties both registers and sets the
// limit to 150000; tready stays low while reset is asserted.
module text_encoding_sniffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // encoding [2:0], has_bom [3], zero [7:4]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic             rdy_q;
  logic             in_vld_q, in_vld_d;
  tes_pkg::item_t   in_q;
  logic             out_vld_q, out_vld_d;
  tes_pkg::result_t out_q;
  logic [31:0]      limit_q;
  logic             adv;
  logic             in_xact;
  tes_pkg::result_t result;

  assign adv = in_vld_q && (!in_q.last_byte || !out_vld_q || m_axis_tready);
  assign s_axis_tready = rdy_q && (!in_vld_q || adv);
  assign in_xact = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xact) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv && in_q.last_byte) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  tes_classifier u_classifier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .limit_i  (limit_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q     <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      limit_q   <= tes_pkg::LimitReset;
    end else begin
      rdy_q     <= 1'b1;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      in_q.data_byte <= s_axis_tdata;
      in_q.last_byte <= s_axis_tlast;
    end
    if (adv && in_q.last_byte) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{tes_pkg::OutPadBits{1'b0}}, out_q.has_bom, out_q.encoding};

endmodule

// File: rtl/tes_classifier.sv
// running per-file encoding tests and the final decision
module tes_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  tes_pkg::item_t    item_i,
  input  logic [31:0]       limit_i,
  output tes_pkg::result_t  result_o
);

  logic        ascii_ok_q, ascii_ok_d;
  logic        latin1_ok_q, latin1_ok_d;
  logic        extended_ok_q, extended_ok_d;
  logic        utf8_ok_q, utf8_ok_d;
  logic [1:0]  pend_q, pend_d;
  logic [2:0]  pos_q, pos_d;
  logic [23:0] header_q, header_d;
  logic [23:0] word_q, word_d;
  logic        big_ok_q, big_ok_d;
  logic        little_ok_q, little_ok_d;
  logic [1:0]  phase_q, phase_d;
  logic        big_bom_q, big_bom_d;
  logic        little_bom_q, little_bom_d;

  logic [7:0]  b;
  logic        is_ascii;
  logic        is_cont;
  logic [31:0] big_word;
  logic [31:0] little_word;
  logic        big_valid;
  logic        little_valid;
  logic        whole;
  tes_pkg::result_t result;

  assign b           = item_i.data_byte;
  assign big_word    = {word_q, b};
  assign little_word = {b, word_q[7:0], word_q[15:8], word_q[23:16]};
  assign is_cont     = (b[7:6] == 2'b10);
  assign is_ascii    = (b >= 8'd32 && b < 8'd127) || (b >= 8'd7 && b < 8'd14) ||
                       (b == 8'd133);

  // next running state for one byte
  always_comb begin
    ascii_ok_d    = ascii_ok_q && is_ascii;
    latin1_ok_d   = latin1_ok_q && (is_ascii || b >= 8'd160);
    extended_ok_d = extended_ok_q && (is_ascii || b >= 8'd128);
    utf8_ok_d     = utf8_ok_q;
    pend_d        = pend_q;
    if (pend_q != 2'd0) begin
      if (!is_cont) begin
        utf8_ok_d = 1'b0;
      end
      pend_d = pend_q - 2'd1;
    end else if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        pend_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pend_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        pend_d = 2'd3;
      end else begin
        utf8_ok_d = 1'b0;
      end
    end

    word_d       = word_q;
    phase_d      = phase_q;
    big_ok_d     = big_ok_q;
    little_ok_d  = little_ok_q;
    big_bom_d    = big_bom_q;
    little_bom_d = little_bom_q;
    big_valid    = big_word < limit_i;
    little_valid = little_word < limit_i;
    if (phase_q != 2'd3) begin
      word_d  = {word_q[15:0], b};
      phase_d = phase_q + 2'd1;
    end else begin
      if (pos_q == 3'd3) begin
        big_bom_d    = (big_word == tes_pkg::Bom32Word);
        little_bom_d = (little_word == tes_pkg::Bom32Word);
        big_valid    = big_valid || big_bom_d;
        little_valid = little_valid || little_bom_d;
      end
      big_ok_d    = big_ok_q && big_valid;
      little_ok_d = little_ok_q && little_valid;
      word_d      = 24'd0;
      phase_d     = 2'd0;
    end

    header_d = header_q;
    if (pos_q < 3'd3) begin
      header_d = {header_q[15:0], b};
    end
    pos_d = pos_q;
    if (pos_q != 3'd7) begin
      pos_d = pos_q + 3'd1;
    end
  end

  // decision on the final byte
  always_comb begin
    whole = (phase_d == 2'd0);
    result.has_bom = 1'b0;
    if (ascii_ok_d) begin
      result.encoding = tes_pkg::ENC_ASCII;
    end else if (utf8_ok_d && pend_d == 2'd0 && pos_d >= 3'd3 &&
                 header_d == tes_pkg::Utf8Bom) begin
      result.encoding = tes_pkg::ENC_UTF8;
      result.has_bom  = 1'b1;
    end else if (utf8_ok_d && pend_d == 2'd0) begin
      result.encoding = tes_pkg::ENC_UTF8;
    end else if (whole && big_ok_d && big_bom_d) begin
      result.encoding = tes_pkg::ENC_UTF32BE;
      result.has_bom  = 1'b1;
    end else if (whole && little_ok_d && little_bom_d) begin
      result.encoding = tes_pkg::ENC_UTF32LE;
      result.has_bom  = 1'b1;
    end else if (whole && big_ok_d) begin
      result.encoding = tes_pkg::ENC_UTF32BE;
    end else if (whole && little_ok_d) begin
      result.encoding = tes_pkg::ENC_UTF32LE;
    end else if (latin1_ok_d) begin
      result.encoding = tes_pkg::ENC_LATIN1;
    end else if (extended_ok_d) begin
      result.encoding = tes_pkg::ENC_EXTENDED;
    end else begin
      result.encoding = tes_pkg::ENC_UNKNOWN;
    end
  end

  assign result_o = result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_ok_q    <= 1'b1;
      latin1_ok_q   <= 1'b1;
      extended_ok_q <= 1'b1;
      utf8_ok_q     <= 1'b1;
      pend_q        <= 2'd0;
      pos_q         <= 3'd0;
      header_q      <= 24'd0;
      word_q        <= 24'd0;
      big_ok_q      <= 1'b1;
      little_ok_q   <= 1'b1;
      phase_q       <= 2'd0;
      big_bom_q     <= 1'b0;
      little_bom_q  <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // start over for the next file
        ascii_ok_q    <= 1'b1;
        latin1_ok_q   <= 1'b1;
        extended_ok_q <= 1'b1;
        utf8_ok_q     <= 1'b1;
        pend_q        <= 2'd0;
        pos_q         <= 3'd0;
        header_q      <= 24'd0;
        word_q        <= 24'd0;
        big_ok_q      <= 1'b1;
        little_ok_q   <= 1'b1;
        phase_q       <= 2'd0;
        big_bom_q     <= 1'b0;
        little_bom_q  <= 1'b0;
      end else begin
        ascii_ok_q    <= ascii_ok_d;
        latin1_ok_q   <= latin1_ok_d;
        extended_ok_q <= extended_ok_d;
        utf8_ok_q     <= utf8_ok_d;
        pend_q        <= pend_d;
        pos_q         <= pos_d;
        header_q      <= header_d;
        word_q        <= word_d;
        big_ok_q      <= big_ok_d;
        little_ok_q   <= little_ok_d;
        phase_q       <= phase_d;
        big_bom_q     <= big_bom_d;
        little_bom_q  <= little_bom_d;
      end
    end
  end

endmodule

// File: rtl/tes_checker.sv
// port-level checks of the text encoding sniffer, bound to the top level
module tes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [2:0] enc;
  assign enc = m_axis_tdata[2:0];

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no unused encoding code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> enc != 3'd7)
    else $error("invalid encoding code");

  // bom flag only with a unicode encoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |->
      (enc == tes_pkg::ENC_UTF8 || enc == tes_pkg::ENC_UTF32BE ||
       enc == tes_pkg::ENC_UTF32LE))
    else $error("bom flag with non-unicode encoding");

  // a fresh result must be preceded by a final byte transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without final byte");

endmodule

bind text_encoding_sniffer tes_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
